// ===== rtl/sitda_pkg.sv =====
// Shared types and constants for the signed integer to decimal ASCII converter.
`timescale 1ns / 1ps

package sitda_pkg;

  // Number of decimal digits in the largest 32-bit magnitude
  localparam int unsigned MAX_DIGITS  = 10;
  localparam int unsigned DIGIT_IDX_W = $clog2(MAX_DIGITS);

  // Reciprocal of ten: floor(x / 10) = (x * DIV10_MAGIC) >> DIV10_SHIFT for 32-bit x
  localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
  localparam int unsigned DIV10_SHIFT = 35;

  // ASCII codes
  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_DIGIT
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic step;
    logic emit_sign;
    logic emit_digit;
  } sitda_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
    logic neg;
    logic rd_last;
    logic out_free;
  } sitda_sts_t;

endpackage

// ===== rtl/sitda_ctrl.sv =====
// Controller state machine: sequences load, digit extraction and character output.
`timescale 1ns / 1ps

module sitda_ctrl
  import sitda_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  sitda_sts_t sts_i,
  output sitda_cmd_t cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        if (sts_i.div_done) begin
          state_d = sts_i.neg ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (sts_i.out_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d         = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_digit = 1'b1;
          if (sts_i.rd_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/sitda_datapath.sv =====
// Datapath: magnitude, divide-by-ten loop, digit store and output register.
`timescale 1ns / 1ps

module sitda_datapath
  import sitda_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic signed [31:0] value_i,
  input  sitda_cmd_t         cmd_i,
  output sitda_sts_t         sts_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         character_o,
  output logic               last_o
);

  logic [31:0]            raw;
  logic [31:0]            mag_in;
  logic [31:0]            mag_q;
  logic [31:0]            prev_q;
  logic                   neg_q;
  logic                   pend_q;
  logic [DIGIT_IDX_W-1:0] nd_q;
  logic [DIGIT_IDX_W-1:0] rd_idx_q;
  logic [3:0]             digit_q [MAX_DIGITS];
  logic [63:0]            prod;
  logic [31:0]            quo;
  logic [3:0]             rem;
  logic                   out_valid_q;
  logic [7:0]             char_q;
  logic                   last_q;

  // Form the unsigned magnitude in 32 bits
  assign raw    = $unsigned(value_i);
  assign mag_in = raw[31] ? (~raw + 32'd1) : raw;

  // Divide by ten through the reciprocal
  assign prod = mag_q * DIV10_MAGIC;
  assign quo  = 32'(prod[63:DIV10_SHIFT]);

  // Remainder of prev_q by ten; mag_q holds its quotient, low four bits suffice
  assign rem = prev_q[3:0] - {mag_q[0], 3'b000} - {mag_q[2:0], 1'b0};

  // Value and digit registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q <= mag_in;
      neg_q <= raw[31];
    end else if (cmd_i.step) begin
      mag_q  <= quo;
      prev_q <= mag_q;
      if (pend_q) begin
        digit_q[nd_q] <= rem;
      end
    end
  end

  // Digit counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= 1'b0;
      nd_q     <= '0;
      rd_idx_q <= '0;
    end else if (cmd_i.load) begin
      pend_q <= 1'b0;
      nd_q   <= '0;
    end else if (cmd_i.step) begin
      pend_q <= 1'b1;
      if (pend_q) begin
        nd_q     <= nd_q + 1'b1;
        rd_idx_q <= nd_q;
      end
    end else if (cmd_i.emit_digit) begin
      rd_idx_q <= rd_idx_q - 1'b1;
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_sign || cmd_i.emit_digit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_sign) begin
      char_q <= ASCII_MINUS;
      last_q <= 1'b0;
    end else if (cmd_i.emit_digit) begin
      char_q <= ASCII_ZERO + {4'b0000, digit_q[rd_idx_q]};
      last_q <= (rd_idx_q == '0);
    end
  end

  // Status toward the controller
  assign sts_o.div_done = pend_q && (mag_q == '0);
  assign sts_o.neg      = neg_q;
  assign sts_o.rd_last  = (rd_idx_q == '0);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule

// ===== rtl/signed_int_to_decimal_ascii_core.sv =====
// Top level: signed 32-bit integer to decimal ASCII character stream.
`timescale 1ns / 1ps

// Input channel: value_i with in_valid_i / in_stall_o; a transaction is taken
// when in_valid_i is high and in_stall_o is low. Output channel: character_o
// and last_o with out_valid_o / out_stall_i; one transaction per character,
// most significant first, with a leading '-' for negative values and last_o
// set on the final digit. Each number gives 1 to 11 characters.
// Sequence: after the input transaction, the divide-by-ten loop does one
// reciprocal multiply per cycle, each remainder taken in the cycle after.
// The characters then load the output register one per cycle while the
// receiver does not stall. The next input is accepted while the last
// character of the previous number still sits in the output register.
// Reset clears the controller and the output valid; no item is in flight.
// When the receiver stalls, the output register holds its character and the
// converter waits before loading the next one.
module signed_int_to_decimal_ascii_core
  import sitda_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         character_o,
  output logic               last_o
);

  sitda_cmd_t cmd;
  sitda_sts_t sts;

  sitda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sitda_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

endmodule
